>>> src/lpmr_pkg.sv
// Shared types and constants of the longest prefix match router.
package lpmr_pkg;

    localparam int ADDR_W     = 32;
    localparam int LEN_W      = 6;
    localparam int IF_W       = 3;
    localparam int TTL_W      = 8;
    localparam int STATUS_W   = 3;
    localparam int IN_DATA_W  = 120;
    localparam int OUT_DATA_W = 48;

    localparam logic [LEN_W-1:0] FULL_LEN = 6'd32;
    localparam logic [TTL_W-1:0] TTL_MIN  = 8'd1;

    localparam logic CMD_ADD   = 1'b0;
    localparam logic CMD_ROUTE = 1'b1;

    localparam logic [STATUS_W-1:0] ST_ADDED       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL        = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FORWARDED   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NO_ROUTE    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_TTL_EXPIRED = 3'd4;

    typedef struct packed {
        logic [ADDR_W-1:0] prefix;
        logic [LEN_W-1:0]  len;
        logic              gw_flag;
        logic [ADDR_W-1:0] gw;
        logic [IF_W-1:0]   ifn;
    } route_t;

    localparam int ROUTE_W = $bits(route_t);

    typedef struct packed {
        logic load_in;
        logic add_write;
        logic scan_init;
        logic issue;
        logic emit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic is_route;
        logic count_zero;
        logic last_addr;
        logic out_free;
    } ctrl_sts_t;

endpackage

>>> src/lpmr_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module lpmr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> src/lpmr_ctrl.sv
// Controller state machine of the longest prefix match router.
module lpmr_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  lpmr_pkg::ctrl_sts_t sts,
    output lpmr_pkg::ctrl_cmd_t cmd
);

    import lpmr_pkg::*;

    typedef enum logic [2:0] {
        IDLE,
        DECODE,
        ADD,
        SCAN,
        DRAIN,
        FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            IDLE:
            begin
                in_ready    = 1'b1;
                cmd.load_in = in_valid;
                if (in_valid)
                begin
                    state_next = DECODE;
                end
            end
            DECODE:
            begin
                if (!sts.is_route)
                begin
                    state_next = ADD;
                end
                else
                begin
                    cmd.scan_init = 1'b1;
                    state_next    = sts.count_zero ? FINISH : SCAN;
                end
            end
            ADD:
            begin
                cmd.add_write = 1'b1;
                state_next    = FINISH;
            end
            SCAN:
            begin
                cmd.issue = 1'b1;
                if (sts.last_addr)
                begin
                    state_next = DRAIN;
                end
            end
            DRAIN:
            begin
                state_next = FINISH;
            end
            FINISH:
            begin
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = IDLE;
                end
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_in |=> state_reg == DECODE)
    else $error("accepted item did not reach decode");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> state_reg == IDLE)
    else $error("result emitted without returning to idle");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.issue |-> sts.is_route && !sts.count_zero)
    else $error("table read issued for a non-route item or empty table");

endmodule

>>> src/lpmr_dp.sv
// Datapath of the longest prefix match router: item registers, table, scan and result.
module lpmr_dp #(
    parameter int MAX_ROUTES     = 16,
    parameter int NUM_INTERFACES = 8
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic [lpmr_pkg::IN_DATA_W-1:0]       s_tdata,
    input  logic                                 s_tuser,
    input  logic                                 m_tready,
    output logic                                 m_tvalid,
    output logic [lpmr_pkg::OUT_DATA_W-1:0]      m_tdata,
    output logic [lpmr_pkg::STATUS_W-1:0]        m_tuser,
    input  lpmr_pkg::ctrl_cmd_t                  cmd,
    output lpmr_pkg::ctrl_sts_t                  sts
);

    import lpmr_pkg::*;

    localparam int AW = (MAX_ROUTES > 1) ? $clog2(MAX_ROUTES) : 1;
    localparam int CW = $clog2(MAX_ROUTES + 1);
    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_ROUTES);
    localparam logic [IF_W-1:0] IF_LAST = IF_W'(NUM_INTERFACES - 1);

    // item registers
    logic              cmd_reg;
    route_t            new_route_reg;
    logic [ADDR_W-1:0] dest_reg;
    logic [TTL_W-1:0]  ttl_reg;

    // table state
    logic [CW-1:0]     count_reg;
    logic              full_reg;
    logic [AW-1:0]     rd_addr_reg;
    logic              cmp_valid_reg;
    route_t            rd_route;
    logic              ram_we;

    // best match so far
    logic              found_reg;
    logic [LEN_W-1:0]  best_len_reg;
    logic              best_gw_flag_reg;
    logic [ADDR_W-1:0] best_gw_reg;
    logic [IF_W-1:0]   best_ifn_reg;

    // result register
    logic                  m_valid_reg;
    logic                  m_valid_next;
    logic [STATUS_W-1:0]   m_status_reg;
    logic [IF_W-1:0]       m_ifn_reg;
    logic [ADDR_W-1:0]     m_nh_reg;
    logic [TTL_W-1:0]      m_ttl_reg;

    logic [LEN_W-1:0]  in_len;
    logic [IF_W-1:0]   in_ifn;
    logic              in_gw_flag;
    logic [ADDR_W-1:0] mask;
    logic              hit;
    logic              better;
    logic [STATUS_W-1:0] res_status;
    logic [IF_W-1:0]   res_ifn;
    logic [ADDR_W-1:0] res_nh;
    logic [TTL_W-1:0]  res_ttl;

    // unpack and clamp the incoming route fields
    always_comb
    begin
        in_len     = s_tdata[37:32];
        in_gw_flag = s_tdata[38];
        in_ifn     = s_tdata[73:71];
        if (in_len > FULL_LEN)
        begin
            in_len = FULL_LEN;
        end
        if (int'(in_ifn) >= NUM_INTERFACES)
        begin
            in_ifn = IF_LAST;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            cmd_reg               <= s_tuser;
            new_route_reg.prefix  <= s_tdata[31:0];
            new_route_reg.len     <= in_len;
            new_route_reg.gw_flag <= in_gw_flag;
            new_route_reg.gw      <= in_gw_flag ? s_tdata[70:39] : '0;
            new_route_reg.ifn     <= in_ifn;
            dest_reg              <= s_tdata[105:74];
            ttl_reg               <= s_tdata[113:106];
        end
    end

    assign ram_we = cmd.add_write && (count_reg != CNT_MAX);

    lpmr_ram #(
        .WIDTH (ROUTE_W),
        .DEPTH (MAX_ROUTES)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[AW-1:0]),
        .wdata (new_route_reg),
        .raddr (rd_addr_reg),
        .rdata (rd_route)
    );

    // prefix compare on the entry read last cycle
    always_comb
    begin
        if (rd_route.len == '0)
        begin
            mask = '0;
        end
        else
        begin
            mask = {ADDR_W{1'b1}} << (FULL_LEN - rd_route.len);
        end
        hit    = ((dest_reg ^ rd_route.prefix) & mask) == '0;
        better = !found_reg || (rd_route.len > best_len_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            full_reg      <= 1'b0;
            rd_addr_reg   <= '0;
            cmp_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
        end
        else
        begin
            cmp_valid_reg <= cmd.issue;
            if (cmd.add_write)
            begin
                full_reg <= (count_reg == CNT_MAX);
            end
            if (ram_we)
            begin
                count_reg <= count_reg + CW'(1);
            end
            if (cmd.scan_init)
            begin
                rd_addr_reg <= '0;
                found_reg   <= 1'b0;
            end
            else
            begin
                if (cmd.issue)
                begin
                    rd_addr_reg <= rd_addr_reg + AW'(1);
                end
                if (cmp_valid_reg && hit && better)
                begin
                    found_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmp_valid_reg && hit && better)
        begin
            best_len_reg     <= rd_route.len;
            best_gw_flag_reg <= rd_route.gw_flag;
            best_gw_reg      <= rd_route.gw;
            best_ifn_reg     <= rd_route.ifn;
        end
    end

    // result of the item at hand
    always_comb
    begin
        res_status = ST_ADDED;
        res_ifn    = '0;
        res_nh     = '0;
        res_ttl    = '0;
        if (cmd_reg == CMD_ADD)
        begin
            res_status = full_reg ? ST_FULL : ST_ADDED;
        end
        else if (!found_reg)
        begin
            res_status = ST_NO_ROUTE;
        end
        else if (ttl_reg <= TTL_MIN)
        begin
            res_status = ST_TTL_EXPIRED;
        end
        else
        begin
            res_status = ST_FORWARDED;
            res_ifn    = best_ifn_reg;
            res_nh     = best_gw_flag_reg ? best_gw_reg : dest_reg;
            res_ttl    = ttl_reg - TTL_MIN;
        end
    end

    always_comb
    begin
        m_valid_next = m_valid_reg;
        if (cmd.emit)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else
        begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            m_status_reg <= res_status;
            m_ifn_reg    <= res_ifn;
            m_nh_reg     <= res_nh;
            m_ttl_reg    <= res_ttl;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = {5'b0, m_ttl_reg, m_nh_reg, m_ifn_reg};

    assign sts.is_route   = (cmd_reg == CMD_ROUTE);
    assign sts.count_zero = (count_reg == '0);
    assign sts.last_addr  = ((CW'(rd_addr_reg) + CW'(1)) == count_reg);
    assign sts.out_free   = !m_valid_reg || m_tready;

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_MAX)
    else $error("route count beyond table size");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.issue |-> CW'(rd_addr_reg) < count_reg)
    else $error("scan read beyond stored routes");

    assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |=> count_reg == $past(count_reg) + CW'(1))
    else $error("route stored without count advance");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> !(m_valid_reg && !m_tready))
    else $error("result overwrote a pending item");

endmodule

>>> src/longest_prefix_match_router.sv
// Top level of the longest prefix match router.
//
// An add item stores one route in the next free table slot, or reports the table full;
// it passes the decode, add and finish states before m_tvalid rises. A route item scans
// the stored routes one per cycle through the table RAM's single read port, keeping the
// longest match with the earliest route winning ties; it passes the decode, scan, drain
// and finish states (decode and finish only for an empty table) before m_tvalid rises.
// One item is in work at a time; the next item is accepted at the edge after the result
// enters the output register, even while that result still waits to be taken, and a
// result that is still waiting holds back the next one. The table needs no clearing after
// reset: only slots below the route count are read.
module longest_prefix_match_router #(
    parameter int MAX_ROUTES     = 16,
    parameter int NUM_INTERFACES = 8
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // prefix, prefix len, gateway flag, gateway, out interface,
    // dest_addr, ttl_in
    input  logic [lpmr_pkg::IN_DATA_W-1:0]       s_tdata,
    // command
    input  logic                                 s_tuser,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // out_interface, forwarding address, ttl_out
    output logic [lpmr_pkg::OUT_DATA_W-1:0]      m_tdata,
    // status
    output logic [lpmr_pkg::STATUS_W-1:0]        m_tuser
);

    import lpmr_pkg::*;

    ctrl_cmd_t cmd;
    ctrl_sts_t sts;

    lpmr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    lpmr_dp #(
        .MAX_ROUTES     (MAX_ROUTES),
        .NUM_INTERFACES (NUM_INTERFACES)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cmd      (cmd),
        .sts      (sts)
    );

endmodule

>>> tb/tb_longest_prefix_match_router.sv
// Stream testbench for the longest prefix match router with a forwarding-table predictor.
`timescale 1ns / 100ps

module tb_longest_prefix_match_router;

    import lpmr_pkg::*;

    localparam int MAX_ROUTES     = 16;
    localparam int NUM_INTERFACES = 8;
    localparam int SWEEP_ITEMS    = 700;
    localparam int FULL_ITEMS     = 930;
    localparam int HOLD_AT        = 300;
    localparam int HOLD_CYCLES    = 400;
    localparam int DRAIN_CYCLES   = 2 * (MAX_ROUTES + 4);

    typedef struct {
        logic              cmd;
        logic [ADDR_W-1:0] prefix;
        logic [LEN_W-1:0]  len;
        logic              gw_flag;
        logic [ADDR_W-1:0] gw;
        logic [IF_W-1:0]   ifn;
        logic [ADDR_W-1:0] dest;
        logic [TTL_W-1:0]  ttl;
    } lpm_item_t;

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [IF_W-1:0]     oif;
        logic [ADDR_W-1:0]   hop_addr;
        logic [TTL_W-1:0]    ttl;
    } lpm_result_t;

    typedef struct {
        lpm_item_t   it;
        bit          typed;
        lpm_result_t want;
    } stim_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata  = '0;
    logic                  s_tuser  = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [STATUS_W-1:0]   m_tuser;

    logic [ADDR_W-1:0] tbl_prefix [MAX_ROUTES];
    logic [LEN_W-1:0]  tbl_len    [MAX_ROUTES];
    logic              tbl_gw_flag[MAX_ROUTES];
    logic [ADDR_W-1:0] tbl_gw     [MAX_ROUTES];
    logic [IF_W-1:0]   tbl_ifn    [MAX_ROUTES];
    int                tbl_count = 0;

    lpm_result_t pending_results[$];
    stim_row_t   directed_rows[$];
    int          fails = 0;
    int          sent  = 0;

    longest_prefix_match_router #(
        .MAX_ROUTES    (MAX_ROUTES),
        .NUM_INTERFACES(NUM_INTERFACES)
    ) u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin : watchdog
        #10_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    function automatic logic [ADDR_W-1:0] prefix_mask(input logic [LEN_W-1:0] len);
        prefix_mask = 32'hFFFF_FFFF << (32 - int'(len));
    endfunction

    function automatic lpm_result_t res(input logic [STATUS_W-1:0] status,
                                        input logic [IF_W-1:0] oif,
                                        input logic [ADDR_W-1:0] hop_addr,
                                        input logic [TTL_W-1:0] ttl);
        lpm_result_t r;
        r.status   = status;
        r.oif      = oif;
        r.hop_addr = hop_addr;
        r.ttl      = ttl;
        return r;
    endfunction

    function automatic lpm_item_t add_item(input logic [ADDR_W-1:0] prefix,
                                           input logic [LEN_W-1:0] len,
                                           input logic gw_flag,
                                           input logic [ADDR_W-1:0] gw,
                                           input logic [IF_W-1:0] ifn);
        lpm_item_t it;
        it.cmd     = CMD_ADD;
        it.prefix  = prefix;
        it.len     = len;
        it.gw_flag = gw_flag;
        it.gw      = gw;
        it.ifn     = ifn;
        it.dest    = $urandom;
        it.ttl     = TTL_W'($urandom_range(0, 255));
        return it;
    endfunction

    function automatic lpm_item_t route_item(input logic [ADDR_W-1:0] dest,
                                             input logic [TTL_W-1:0] ttl);
        lpm_item_t it;
        it.cmd     = CMD_ROUTE;
        it.prefix  = $urandom;
        it.len     = LEN_W'($urandom_range(0, 63));
        it.gw_flag = 1'($urandom_range(0, 1));
        it.gw      = $urandom;
        it.ifn     = IF_W'($urandom_range(0, 7));
        it.dest    = dest;
        it.ttl     = ttl;
        return it;
    endfunction

    function automatic lpm_result_t route_table_step(input lpm_item_t it);
        lpm_result_t r;
        logic [LEN_W-1:0] len;
        int best;
        bit found;
        r = res(ST_ADDED, '0, '0, '0);
        if (it.cmd == CMD_ADD)
        begin
            if (tbl_count >= MAX_ROUTES)
            begin
                r.status = ST_FULL;
            end
            else
            begin
                len = (it.len > FULL_LEN) ? FULL_LEN : it.len;
                tbl_prefix[tbl_count]  = it.prefix;
                tbl_len[tbl_count]     = len;
                tbl_gw_flag[tbl_count] = it.gw_flag;
                tbl_gw[tbl_count]      = it.gw_flag ? it.gw : '0;
                tbl_ifn[tbl_count]     = (int'(it.ifn) >= NUM_INTERFACES)
                                         ? IF_W'(NUM_INTERFACES - 1) : it.ifn;
                tbl_count++;
            end
        end
        else
        begin
            found = 1'b0;
            best  = 0;
            for (int i = 0; i < tbl_count; i++)
            begin
                if ((((it.dest ^ tbl_prefix[i]) & prefix_mask(tbl_len[i])) == '0) &&
                    (!found || tbl_len[i] > tbl_len[best]))
                begin
                    best  = i;
                    found = 1'b1;
                end
            end
            if (!found)
            begin
                r.status = ST_NO_ROUTE;
            end
            else if (it.ttl <= TTL_MIN)
            begin
                r.status = ST_TTL_EXPIRED;
            end
            else
            begin
                r.status   = ST_FORWARDED;
                r.oif      = tbl_ifn[best];
                r.hop_addr = tbl_gw_flag[best] ? tbl_gw[best] : it.dest;
                r.ttl      = it.ttl - 8'd1;
            end
        end
        return r;
    endfunction

    function automatic lpm_item_t random_item(input bit is_add);
        lpm_item_t it;
        int k;
        logic [ADDR_W-1:0] mask;
        it = route_item($urandom, TTL_W'($urandom_range(0, 255)));
        it.len = LEN_W'($urandom_range(1, 63));
        if (is_add)
        begin
            it.cmd = CMD_ADD;
            if ($urandom_range(0, 3) != 0)
                it.len = LEN_W'($urandom_range(1, 32));
            if (tbl_count > 0 && $urandom_range(0, 1) == 1)
            begin
                k = $urandom_range(0, tbl_count - 1);
                mask = prefix_mask(tbl_len[k]);
                it.prefix = (tbl_prefix[k] & mask) | (it.prefix & ~mask);
            end
        end
        else
        begin
            case ($urandom_range(0, 19))
                0:       it.ttl = 8'd0;
                1:       it.ttl = 8'd1;
                2:       it.ttl = 8'd2;
                3:       it.ttl = 8'd255;
                default: it.ttl = TTL_W'($urandom_range(2, 255));
            endcase
            if (tbl_count > 0 && $urandom_range(0, 9) < 7)
            begin
                k = $urandom_range(0, tbl_count - 1);
                mask = prefix_mask(tbl_len[k]);
                it.dest = (tbl_prefix[k] & mask) | (it.dest & ~mask);
                if ($urandom_range(0, 9) == 0 && tbl_len[k] != '0)
                    it.dest ^= 32'h1 << (32 - int'(tbl_len[k]));
            end
        end
        return it;
    endfunction

    task automatic add_row(input lpm_item_t it, input bit typed, input lpm_result_t want);
        stim_row_t row;
        row.it    = it;
        row.typed = typed;
        row.want  = want;
        directed_rows.insert(directed_rows.size(), row);
    endtask

    task automatic send_item(input lpm_item_t it, input bit typed, input lpm_result_t want);
        int gap;
        lpm_result_t predicted;
        gap = (((sent / 80) % 4) == 1) ? 0 : $urandom_range(0, 19);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.cmd;
        s_tdata  <= {6'd0, it.ttl, it.dest, it.ifn, it.gw, it.gw_flag, it.len, it.prefix};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        predicted = route_table_step(it);
        pending_results.insert(pending_results.size(), typed ? want : predicted);
        sent++;
    endtask

    initial
    begin : item_source
        lpm_item_t it;
        lpm_result_t added;
        added = res(ST_ADDED, '0, '0, '0);

        add_row(route_item(32'h0A00_0001, 8'd64), 1, res(ST_NO_ROUTE, '0, '0, '0));
        add_row(add_item(32'h0A00_0000, 6'd8, 1'b0, 32'h0000_0000, 3'd1), 1, added);
        add_row(add_item(32'h0A01_0000, 6'd16, 1'b1, 32'hC0A8_0001, 3'd2), 1, added);
        add_row(add_item(32'h0A01_0000, 6'd16, 1'b1, 32'hC0A8_00FE, 3'd3), 1, added);
        add_row(add_item(32'hFFFF_FFFF, 6'd63, 1'b1, 32'hFFFF_FFFF, 3'd7), 1, added);
        add_row(add_item(32'h0000_0000, 6'd32, 1'b0, 32'hDEAD_BEEF, 3'd0), 1, added);
        add_row(add_item(32'hC0A8_0000, 6'd24, 1'b0, 32'hFFFF_FFFF, 3'd5), 1, added);
        add_row(add_item(32'h8000_0000, 6'd1, 1'b1, 32'h0102_0304, 3'd6), 1, added);
        add_row(route_item(32'h0A01_0203, 8'd64), 0, added);
        add_row(route_item(32'h0A7F_0000, 8'd2), 0, added);
        add_row(route_item(32'h0A00_0001, 8'd1), 1, res(ST_TTL_EXPIRED, '0, '0, '0));
        add_row(route_item(32'h0A00_0001, 8'd0), 1, res(ST_TTL_EXPIRED, '0, '0, '0));
        add_row(route_item(32'hFFFF_FFFF, 8'd255), 1,
                res(ST_FORWARDED, 3'd7, 32'hFFFF_FFFF, 8'd254));
        add_row(route_item(32'h0000_0000, 8'd255), 1,
                res(ST_FORWARDED, 3'd0, 32'h0000_0000, 8'd254));
        add_row(route_item(32'h7FFF_FFFF, 8'd200), 1, res(ST_NO_ROUTE, '0, '0, '0));
        add_row(route_item(32'h7FFF_FFFF, 8'd1), 1, res(ST_NO_ROUTE, '0, '0, '0));
        add_row(route_item(32'hC0A8_00FF, 8'd10), 0, added);
        add_row(route_item(32'hFFFF_FFFE, 8'd3), 0, added);
        add_row(route_item(32'h0A01_00FF, 8'd255), 0, added);

        while (rst_n !== 1'b1) @(posedge clk);
        @(posedge clk);

        foreach (directed_rows[i])
            send_item(directed_rows[i].it, directed_rows[i].typed, directed_rows[i].want);

        repeat (SWEEP_ITEMS)
            send_item(random_item(tbl_count < MAX_ROUTES - 1 && $urandom_range(0, 6) == 0),
                      0, added);

        // drain before installing the default route
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        it = random_item(1);
        it.len = '0;
        send_item(it, 0, added);

        repeat (FULL_ITEMS)
            send_item(random_item($urandom_range(0, 9) == 0), 0, added);

        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fails == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin : result_sink
        int gap;
        int taken;
        lpm_result_t got;
        lpm_result_t want;
        taken = 0;
        while (rst_n !== 1'b1) @(posedge clk);
        forever
        begin
            gap = (((taken / 70) % 3) == 2) ? 0 : $urandom_range(0, 19);
            if (taken == HOLD_AT)
                gap = HOLD_CYCLES;
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid) @(posedge clk);
            got.status   = m_tuser;
            got.oif      = m_tdata[2:0];
            got.hop_addr = m_tdata[34:3];
            got.ttl      = m_tdata[42:35];
            if (pending_results.size() == 0)
            begin
                fails++;
                if (fails <= 10)
                    $display("unexpected result: status=%0d oif=%0d hop=%h ttl=%0d",
                             got.status, got.oif, got.hop_addr, got.ttl);
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.status !== want.status || got.oif !== want.oif ||
                    got.hop_addr !== want.hop_addr || got.ttl !== want.ttl)
                begin
                    fails++;
                    if (fails <= 10)
                        $display({"mismatch on result %0d: expected status=%0d oif=%0d ",
                                  "hop=%h ttl=%0d, got status=%0d oif=%0d ",
                                  "hop=%h ttl=%0d"},
                                 taken, want.status, want.oif, want.hop_addr, want.ttl,
                                 got.status, got.oif, got.hop_addr, got.ttl);
                end
            end
            taken++;
        end
    end

endmodule

>>> filelist.f
src/lpmr_pkg.sv
src/lpmr_ram.sv
src/lpmr_ctrl.sv
src/lpmr_dp.sv
src/longest_prefix_match_router.sv
tb/tb_longest_prefix_match_router.sv
